[rtl/per_cpu_splitmix64_generator_unit_macros.svh]
// Assertion macros for the per-processor splitmix64 generator.
// Used by the top level only; needs no other file.
`ifndef PER_CPU_SPLITMIX64_GENERATOR_UNIT_MACROS_SVH
`define PER_CPU_SPLITMIX64_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCSM64_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pcsm64 same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCSM64_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pcsm64 next-cycle check failed");

`endif

[rtl/pcsm64_pkg.sv]
// Shared types and constants of the per-processor splitmix64 generator.
// No dependencies; imported by every module of the block.
package pcsm64_pkg;

  localparam int unsigned DEFAULT_PROCESSOR_COUNT = 16;
  localparam int unsigned IN_INDEX_WIDTH = 4;
  localparam int unsigned IN_INDEX_SPAN = 2 ** IN_INDEX_WIDTH;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

  // Partial-product phases of the shared 32x32 multiplier.
  localparam logic [1:0] MUL_PH_LL   = 2'd0;
  localparam logic [1:0] MUL_PH_LH   = 2'd1;
  localparam logic [1:0] MUL_PH_HL   = 2'd2;
  localparam logic [1:0] MUL_PH_LAST = 2'd3;

  typedef struct packed {
    logic [IN_INDEX_WIDTH-1:0] processor_index;
    logic [63:0]               counter_sample;
  } req_t;

  typedef struct packed {
    logic [63:0] random_value;
    logic        was_seeded_now;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       read;
    logic       advance;
    logic       mul_en;
    logic [1:0] mul_phase;
    logic       mul_pass;
    logic       mix;
    logic       finish;
  } dp_cmd_t;

endpackage

[rtl/pcsm64_datapath.sv]
// Datapath: per-processor state memory, seeding, step and shared multiplier.
// Depends on pcsm64_pkg; driven by pcsm64_controller commands.
module pcsm64_datapath import pcsm64_pkg::*; #(
  parameter int unsigned ProcessorCount = DEFAULT_PROCESSOR_COUNT
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dp_cmd_t cmd_i,
  input  req_t    req_i,
  output rsp_t    rsp_o
);

  localparam int unsigned IdxW  = (ProcessorCount > 1) ? $clog2(ProcessorCount) : 1;
  localparam int unsigned SeedW = 32 + IdxW + 1;

  // Constant map of the incoming index onto an existing entry.
  logic [IdxW-1:0] idx_map [IN_INDEX_SPAN];
  for (genvar g = 0; g < IN_INDEX_SPAN; g++) begin : g_idx_map
    assign idx_map[g] = IdxW'(g % ProcessorCount);
  end

  logic [IdxW-1:0]  proc_d, proc_q;
  logic [IdxW:0]    proc_plus1;
  logic [SeedW-1:0] seed_lo_d, seed_hi_full;
  logic [SeedW-1:0] seed_lo_q;
  logic [31:0]      seed_hi_q;
  logic [63:0]      counter_q;
  logic [63:0]      seed_q;

  logic [63:0] state_mem_q [ProcessorCount];
  logic [ProcessorCount-1:0] valid_q;
  logic [63:0] rdata_q;
  logic        rd_valid_q;

  logic        keep_state;
  logic [63:0] st_sel, st_new;
  logic        seeded_q;

  logic [63:0] z_q, acc_q, prod_q;
  logic [63:0] mul_k;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  rsp_t        rsp_q;

  assign proc_d       = idx_map[req_i.processor_index];
  assign proc_plus1   = {1'b0, proc_d} + {{IdxW{1'b0}}, 1'b1};
  assign seed_lo_d    = GOLDEN_GAMMA[31:0] * proc_plus1;
  assign seed_hi_full = GOLDEN_GAMMA[63:32] * proc_plus1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      proc_q    <= proc_d;
      counter_q <= req_i.counter_sample;
      seed_lo_q <= seed_lo_d;
      seed_hi_q <= seed_hi_full[31:0];
    end
    if (cmd_i.read) begin
      seed_q  <= 64'(seed_lo_q) + {seed_hi_q, 32'b0};
      rdata_q <= state_mem_q[proc_q];
    end
    if (cmd_i.advance) begin
      state_mem_q[proc_q] <= st_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.read) begin
        rd_valid_q <= valid_q[proc_q];
      end
      if (cmd_i.advance) begin
        valid_q[proc_q] <= 1'b1;
      end
    end
  end

  // An entry never written reads as invalid, and a zero state also counts as unseeded.
  assign keep_state = rd_valid_q && (rdata_q != 64'd0);
  assign st_sel     = keep_state ? rdata_q : ((counter_q ^ seed_q) | 64'd1);
  assign st_new     = st_sel + GOLDEN_GAMMA;

  // Low 64 bits of z * k from three 32x32 partial products.
  assign mul_k = cmd_i.mul_pass ? MIX_MUL_B : MIX_MUL_A;

  always_comb begin
    case (cmd_i.mul_phase)
      MUL_PH_LL: begin
        mul_a = z_q[31:0];
        mul_b = mul_k[31:0];
      end
      MUL_PH_LH: begin
        mul_a = z_q[31:0];
        mul_b = mul_k[63:32];
      end
      default: begin
        mul_a = z_q[63:32];
        mul_b = mul_k[31:0];
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      z_q      <= st_new ^ (st_new >> 30);
      seeded_q <= !keep_state;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
      case (cmd_i.mul_phase)
        MUL_PH_LL:   acc_q <= acc_q;
        MUL_PH_LH:   acc_q <= prod_q;
        default:     acc_q <= acc_q + {prod_q[31:0], 32'b0};
      endcase
    end
    if (cmd_i.mix) begin
      z_q <= acc_q ^ (acc_q >> 27);
    end
    if (cmd_i.finish) begin
      rsp_q.random_value   <= acc_q ^ (acc_q >> 31);
      rsp_q.was_seeded_now <= seeded_q;
    end
  end

  assign rsp_o = rsp_q;

endmodule

[rtl/pcsm64_controller.sv]
// Controller: sequences read, step, two multiplies and the result strobe.
// Depends on pcsm64_pkg; drives pcsm64_datapath through dp_cmd_t.
module pcsm64_controller import pcsm64_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  output logic    busy_o,
  output logic    done_o,
  output dp_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_READ    = 6'b000010,
    ST_ADVANCE = 6'b000100,
    ST_MULT    = 6'b001000,
    ST_MIX     = 6'b010000,
    ST_FINISH  = 6'b100000
  } state_e;

  state_e     state_d, state_q;
  logic [1:0] phase_d, phase_q;
  logic       pass_d, pass_q;
  logic       done_d, done_q;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    pass_d  = pass_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    cmd_o.mul_phase = phase_q;
    cmd_o.mul_pass  = pass_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          phase_d    = MUL_PH_LL;
          pass_d     = 1'b0;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_ADVANCE;
      end
      ST_ADVANCE: begin
        cmd_o.advance = 1'b1;
        state_d       = ST_MULT;
      end
      ST_MULT: begin
        cmd_o.mul_en = 1'b1;
        phase_d      = phase_q + 2'd1;
        if (phase_q == MUL_PH_LAST) begin
          state_d = pass_q ? ST_FINISH : ST_MIX;
        end
      end
      ST_MIX: begin
        cmd_o.mix = 1'b1;
        pass_d    = 1'b1;
        phase_d   = MUL_PH_LL;
        state_d   = ST_MULT;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        done_d       = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= MUL_PH_LL;
      pass_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      pass_q  <= pass_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

[rtl/per_cpu_splitmix64_generator_unit.sv]
// Top level of the per-processor splitmix64 generator.
// Depends on pcsm64_pkg, pcsm64_controller, pcsm64_datapath and the macros header.
//
// Usage:
//   A request (processor index, cycle counter sample) is taken at a rising
//   edge where start_i is high and busy_o is low. busy_o then stays high
//   while the draw is computed, and the result appears on result_o for
//   exactly one cycle with result_valid_o high; the receiver must take it
//   then, since it cannot stall the block.
//   The block takes no new request while busy_o is high. A new request can
//   be taken in the cycle the result is shown. The draw is sequenced on the
//   single shared 32x32 multiplier: each 64-bit finalizer multiply is built
//   from three partial products in turn, and there are two, after one memory
//   read and one step.
//   Reset clears all per-processor valid bits at once, so every state reads
//   as unseeded after reset; no clearing pass is needed.
`include "per_cpu_splitmix64_generator_unit_macros.svh"

module per_cpu_splitmix64_generator_unit import pcsm64_pkg::*; #(
  parameter int unsigned ProcessorCount = DEFAULT_PROCESSOR_COUNT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic result_valid_o,
  output rsp_t result_o
);

  dp_cmd_t cmd;

  pcsm64_controller u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (result_valid_o),
    .cmd_o   (cmd)
  );

  pcsm64_datapath #(
    .ProcessorCount (ProcessorCount)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (result_o)
  );

  `PCSM64_ASSERT_NEXT(a_accept_sets_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `PCSM64_ASSERT_NOW(a_strobe_when_idle, clk_i, rst_ni, result_valid_o, !busy_o)
  `PCSM64_ASSERT_NEXT(a_strobe_one_cycle, clk_i, rst_ni, result_valid_o, !result_valid_o)
  `PCSM64_ASSERT_NOW(a_strobe_after_busy, clk_i, rst_ni, result_valid_o, $past(busy_o))

endmodule
